@@ rtl/core/mppctbp_pkg.sv @@
// MPPC token bit packer: shared types, codes and code-table constants.
// No dependencies; compiled first.
`default_nettype none

package mppctbp_pkg;

  // Token kinds on the input channel
  localparam logic [1:0] MODE_LITERAL = 2'd0;
  localparam logic [1:0] MODE_COPY    = 2'd1;
  localparam logic [1:0] MODE_FLUSH   = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  // Widths of the packed code and the pending bit store
  localparam int unsigned CODE_W  = 49;  // longest token code: 19 offset + 30 length bits
  localparam int unsigned NBITS_W = 6;
  localparam int unsigned ACC_W   = 56;  // seven pending bits plus the longest code
  localparam int unsigned CNT_W   = 6;

  // Literal escape prefix for bytes of 0x80 and above
  localparam logic [1:0] LIT_ESC_PFX = 2'b10;

  // Offset bucket prefixes
  localparam logic [3:0] PFX_8K_SHORT  = 4'hF;
  localparam logic [3:0] PFX_8K_MID    = 4'hE;
  localparam logic [4:0] PFX_64K_SHORT = 5'h1F;
  localparam logic [4:0] PFX_64K_MID   = 5'h1E;
  localparam logic [3:0] PFX_64K_WIDE  = 4'hE;
  localparam logic [2:0] PFX_LONG      = 3'h6;

  // Offset bucket bases and range limits
  localparam logic [15:0] OFS_MID_BASE      = 16'd64;
  localparam logic [15:0] OFS_LONG_BASE_8K  = 16'd320;
  localparam logic [15:0] OFS_WIDE_BASE_64K = 16'd320;
  localparam logic [15:0] OFS_LONG_BASE_64K = 16'd2368;
  localparam logic [15:0] OFS_MAX_8K        = 16'd8191;
  localparam logic [15:0] LEN_MIN           = 16'd3;
  localparam logic [15:0] LEN_MAX_8K        = 16'd8191;

  // Work item kinds passed from front to back
  typedef enum logic [1:0] {
    KIND_BITS,
    KIND_FLUSH,
    KIND_ERROR
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [CODE_W-1:0]   code;
    logic [NBITS_W-1:0]  nbits;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/mppctbp_if.sv @@
// Channel interfaces of the MPPC token bit packer: tokens, output bytes
// and the configuration write. No dependencies.
`default_nettype none

interface mppctbp_tok_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  literal_byte;
  logic [15:0] match_dist;
  logic [15:0] match_len;

  modport source (output valid, mode, literal_byte, match_dist, match_len, input ready);
  modport sink   (input valid, mode, literal_byte, match_dist, match_len, output ready);
endinterface

interface mppctbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

interface mppctbp_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mppctbp_front.sv @@
// Front end: accepts tokens, checks ranges and builds each token's code word.
// Depends on mppctbp_pkg and the token channel interface.
`default_nettype none

module mppctbp_front import mppctbp_pkg::*; (
  mppctbp_tok_if.sink tok_i,
  input  wire logic   dict_mode_i,
  input  wire logic   q_ready_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic [15:0]  off;
  logic [15:0]  len;
  logic [15:0]  off_m_mid;
  logic [15:0]  off_m_long8k;
  logic [15:0]  off_m_wide;
  logic [15:0]  off_m_long64k;
  logic [18:0]  ocode;
  logic [4:0]   olen;
  logic [3:0]   kb;
  logic [15:0]  low_mask;
  logic [15:0]  ones_code;
  logic [29:0]  lcode;
  logic [4:0]   llen;
  logic         range_err;
  logic [CODE_W-1:0] copy_code;

  assign off = tok_i.match_dist;
  assign len = tok_i.match_len;

  // Take a token whenever the queue has room; unused mode codes are dropped
  assign tok_i.ready = q_ready_i;
  assign push_o      = tok_i.valid && q_ready_i && (tok_i.mode != MODE_UNUSED);

  assign off_m_mid     = off - OFS_MID_BASE;
  assign off_m_long8k  = off - OFS_LONG_BASE_8K;
  assign off_m_wide    = off - OFS_WIDE_BASE_64K;
  assign off_m_long64k = off - OFS_LONG_BASE_64K;

  // Offset bucket code
  always_comb begin
    if (!dict_mode_i) begin
      priority if (off < OFS_MID_BASE) begin
        ocode = {9'd0, PFX_8K_SHORT, off[5:0]};
        olen  = 5'd10;
      end else if (off < OFS_LONG_BASE_8K) begin
        ocode = {7'd0, PFX_8K_MID, off_m_mid[7:0]};
        olen  = 5'd12;
      end else begin
        ocode = {3'd0, PFX_LONG, off_m_long8k[12:0]};
        olen  = 5'd16;
      end
    end else begin
      priority if (off < OFS_MID_BASE) begin
        ocode = {8'd0, PFX_64K_SHORT, off[5:0]};
        olen  = 5'd11;
      end else if (off < OFS_WIDE_BASE_64K) begin
        ocode = {6'd0, PFX_64K_MID, off_m_mid[7:0]};
        olen  = 5'd13;
      end else if (off < OFS_LONG_BASE_64K) begin
        ocode = {4'd0, PFX_64K_WIDE, off_m_wide[10:0]};
        olen  = 5'd15;
      end else begin
        ocode = {PFX_LONG, off_m_long64k};
        olen  = 5'd19;
      end
    end
  end

  // Find the length bucket: position of the leading one
  always_comb begin
    kb = 4'd2;
    for (int i = 2; i < 16; i++) begin
      if (len[i]) kb = 4'(i);
    end
  end

  // Unary prefix of kb-1 ones and a zero, then the low kb bits
  assign low_mask  = ~(16'hFFFF << kb);
  assign ones_code = low_mask & ~16'h0001;

  always_comb begin
    if (len == LEN_MIN) begin
      lcode = '0;
      llen  = 5'd1;
    end else begin
      lcode = ({14'd0, ones_code} << kb) | {14'd0, len & low_mask};
      llen  = {kb, 1'b0};
    end
  end

  assign copy_code = ({30'd0, ocode} << llen) | {19'd0, lcode};

  assign range_err = (!dict_mode_i && (off > OFS_MAX_8K)) || (len < LEN_MIN) ||
                     (!dict_mode_i && (len > LEN_MAX_8K));

  // Classify the token into one work item
  always_comb begin
    entry_o.kind  = KIND_BITS;
    entry_o.code  = '0;
    entry_o.nbits = '0;
    unique case (tok_i.mode)
      MODE_LITERAL: begin
        if (!tok_i.literal_byte[7]) begin
          entry_o.code  = {{(CODE_W-8){1'b0}}, tok_i.literal_byte};
          entry_o.nbits = NBITS_W'(8);
        end else begin
          entry_o.code  = {{(CODE_W-9){1'b0}}, LIT_ESC_PFX, tok_i.literal_byte[6:0]};
          entry_o.nbits = NBITS_W'(9);
        end
      end
      MODE_COPY: begin
        if (range_err) begin
          entry_o.kind = KIND_ERROR;
        end else begin
          entry_o.code  = copy_code;
          entry_o.nbits = NBITS_W'(olen) + NBITS_W'(llen);
        end
      end
      MODE_FLUSH: begin
        entry_o.kind = KIND_FLUSH;
      end
      default: begin
        entry_o.kind = KIND_BITS;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/mppctbp_queue.sv @@
// Two-entry queue of work items between the front and back ends.
// Depends on mppctbp_pkg.
`default_nettype none

module mppctbp_queue import mppctbp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  output logic        ready_o,
  output logic        valid_o,
  input  wire logic   pop_i,
  output entry_t      entry_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mppctbp_back.sv @@
// Back end: appends code words to the pending bit store and emits bytes,
// one per cycle unless the output stalls, through a registered output stage.
// Depends on mppctbp_pkg and the output channel interface.
`default_nettype none

module mppctbp_back import mppctbp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_valid_i,
  input  wire entry_t   q_entry_i,
  output logic          q_pop_o,
  mppctbp_out_if.source res_o
);

  logic [ACC_W-1:0] acc_q, acc_d, acc_post;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_post;
  logic             flush_q, flush_d, flush_post;
  logic             err_q, err_d, err_post;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_err_q, out_err_d;

  logic             cnt_ge8;
  logic             have_byte;
  logic             emit;
  logic [CNT_W-1:0] rem;
  logic [ACC_W-1:0] acc_shr;
  logic [7:0]       byte_full;
  logic [7:0]       byte_pad;
  logic [3:0]       pad_shift;
  logic             last_full;
  logic [7:0]       b_byte;
  logic             b_last;
  logic             b_err;

  assign cnt_ge8   = (cnt_q[CNT_W-1:3] != '0);
  assign have_byte = err_q || cnt_ge8 || flush_q;
  assign emit      = have_byte && (!out_valid_q || res_o.ready);

  assign rem       = cnt_q - CNT_W'(8);
  assign acc_shr   = acc_q >> rem;
  assign byte_full = acc_shr[7:0];
  assign pad_shift = 4'd8 - {1'b0, cnt_q[2:0]};
  assign byte_pad  = acc_q[7:0] << pad_shift;
  assign last_full = (rem < CNT_W'(8)) && !(flush_q && (rem != '0));

  // Pick the next byte and the state left after it
  always_comb begin
    acc_post   = acc_q;
    cnt_post   = cnt_q;
    flush_post = flush_q;
    err_post   = err_q;
    b_byte     = '0;
    b_last     = 1'b1;
    b_err      = 1'b0;
    priority if (err_q) begin
      b_err    = 1'b1;
      err_post = 1'b0;
    end else if (cnt_ge8) begin
      b_byte     = byte_full;
      b_last     = last_full;
      cnt_post   = rem;
      flush_post = flush_q && (rem != '0);
    end else begin
      b_byte     = byte_pad;
      cnt_post   = '0;
      flush_post = 1'b0;
    end
    if (!emit) begin
      acc_post   = acc_q;
      cnt_post   = cnt_q;
      flush_post = flush_q;
      err_post   = err_q;
    end
  end

  // Take the next item once the current one has nothing left to send
  assign q_pop_o = q_valid_i && (!have_byte || (emit && b_last));

  always_comb begin
    acc_d   = acc_post;
    cnt_d   = cnt_post;
    flush_d = flush_post;
    err_d   = err_post;
    if (q_pop_o) begin
      unique case (q_entry_i.kind)
        KIND_BITS: begin
          acc_d = (acc_post << q_entry_i.nbits) | ACC_W'(q_entry_i.code);
          cnt_d = cnt_post + CNT_W'(q_entry_i.nbits);
        end
        KIND_FLUSH: flush_d = (cnt_post != '0);
        KIND_ERROR: err_d   = 1'b1;
        default:    err_d   = err_post;
      endcase
    end
  end

  // Output register: load on emit, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = b_byte;
      out_last_d  = b_last;
      out_err_d   = b_err;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      flush_q     <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      flush_q     <= flush_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.out_byte = out_byte_q;
  assign res_o.last     = out_last_q;
  assign res_o.error    = out_err_q;

endmodule

`default_nettype wire

@@ rtl/core/mppct_token_bit_packer_placeholder_unused.sv @@
// Dictionary mode register for the MPPC token bit packer.
// Depends on mppctbp_pkg and the configuration channel interface.
`default_nettype none

module mppctbp_cfg_reg import mppctbp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mppctbp_cfg_if.sink cfg_i,
  output logic        dict_mode_o
);

  logic dict_mode_q, dict_mode_d;

  // Always take writes; hold the mode between them
  assign cfg_i.ready = 1'b1;
  assign dict_mode_d = (cfg_i.valid) ? cfg_i.data : dict_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_mode_q <= 1'b0;
    end else begin
      dict_mode_q <= dict_mode_d;
    end
  end

  assign dict_mode_o = dict_mode_q;

endmodule

`default_nettype wire

@@ rtl/core/mppc_token_bit_packer.sv @@
// MPPC token bit packer, top level. With an idle back end and output, an
// accepted token passes the queue, the pending bit store and the output
// register before its first byte is valid. Bytes leave one per cycle from
// the bit store shifter unless the output stalls.
// Reset: asynchronous, active low; clears the bit store, queue and mode (8K).
`default_nettype none

module mppc_token_bit_packer import mppctbp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  mppctbp_cfg_if.sink   cfg_i,
  mppctbp_tok_if.sink   tok_i,
  mppctbp_out_if.source res_o
);

  logic   dict_mode;
  logic   q_push;
  logic   q_ready;
  logic   q_valid;
  logic   q_pop;
  entry_t front_entry;
  entry_t q_entry;

  mppctbp_cfg_reg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .dict_mode_o (dict_mode)
  );

  mppctbp_front u_front (
    .tok_i       (tok_i),
    .dict_mode_i (dict_mode),
    .q_ready_i   (q_ready),
    .push_o      (q_push),
    .entry_o     (front_entry)
  );

  mppctbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (q_entry)
  );

  mppctbp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

  // An error transaction is a single zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.error |-> res_o.last && (res_o.out_byte == 8'd0))
    else $error("error transaction not a single zero byte");

  // A byte that is not the last of its token is followed by another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.last |=> res_o.valid)
    else $error("token bytes interrupted");

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_ready)
    else $error("push into full queue");

endmodule

`default_nettype wire
